// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the frame receiver modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is held.
`define PLD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define PLD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- design/pld_pkg.sv -----
// ---------------------------------------------------------------------------
// pld_pkg
// Shared types and constants of the preamble/length frame receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pld_pkg;

    localparam logic [31:0] SYNC_PATTERN_RESET = 32'hAA55_C33C;
    localparam int          QUEUE_DEPTH_DEF    = 4;
    localparam logic [7:0]  LENGTH_MIN         = 8'd2;
    localparam logic [7:0]  INDEX_ID           = 8'd0;
    localparam logic [7:0]  INDEX_LENGTH       = 8'd1;

    // One queued command: a header (pair) gives two beats, id then length.
    typedef struct packed {
        logic       pair;
        logic [7:0] id_byte;
        logic [7:0] data_byte;
        logic [7:0] index;
        logic       last;
        logic       bad;
    } pld_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pld_qstat_t;

endpackage

`default_nettype wire

// ----- design/pld_front.sv -----
// ---------------------------------------------------------------------------
// pld_front
// Preamble hunt, header capture and byte classification into commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pld_front import pld_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        cfg_valid,
    input  wire logic [31:0] cfg_data,
    input  wire pld_qstat_t  qstat,
    output logic             push,
    output pld_cmd_t         cmd
);

    typedef enum logic [6:0] {
        ST_PRE0 = 7'b0000001,
        ST_PRE1 = 7'b0000010,
        ST_PRE2 = 7'b0000100,
        ST_PRE3 = 7'b0001000,
        ST_ID   = 7'b0010000,
        ST_LEN  = 7'b0100000,
        ST_DATA = 7'b1000000
    } hunt_state_t;

    hunt_state_t state_reg, state_next;
    logic [31:0] sync_reg, sync_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  taken_reg, taken_next;
    logic        accept;
    logic [8:0]  taken_sum;
    logic        data_last;

    assign s_tready  = !qstat.full;
    assign accept    = s_tvalid && s_tready;
    assign taken_sum = {1'b0, taken_reg} + 9'd1;
    assign data_last = taken_sum >= {1'b0, len_reg};

    always_comb begin
        state_next = state_reg;
        sync_next  = cfg_valid ? cfg_data : sync_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        taken_next = taken_reg;
        push       = 1'b0;
        cmd        = '0;
        if (accept) begin
            case (state_reg)
                ST_PRE0: state_next = (s_tdata == sync_reg[31:24]) ? ST_PRE1 : ST_PRE0;
                ST_PRE1: state_next = (s_tdata == sync_reg[23:16]) ? ST_PRE2 : ST_PRE0;
                ST_PRE2: state_next = (s_tdata == sync_reg[15:8])  ? ST_PRE3 : ST_PRE0;
                ST_PRE3: state_next = (s_tdata == sync_reg[7:0])   ? ST_ID   : ST_PRE0;
                ST_ID: begin
                    id_next    = s_tdata;
                    state_next = ST_LEN;
                end
                ST_LEN: begin
                    push           = 1'b1;
                    cmd.data_byte  = s_tdata;
                    cmd.index      = INDEX_LENGTH;
                    cmd.id_byte    = id_reg;
                    if (s_tdata < LENGTH_MIN) begin
                        // drop the frame, report the length as an error beat
                        cmd.last   = 1'b1;
                        cmd.bad    = 1'b1;
                        state_next = ST_PRE0;
                    end else begin
                        cmd.pair = 1'b1;
                        cmd.last = (s_tdata == LENGTH_MIN);
                        if (s_tdata == LENGTH_MIN) begin
                            state_next = ST_PRE0;
                        end else begin
                            len_next   = s_tdata;
                            taken_next = LENGTH_MIN;
                            state_next = ST_DATA;
                        end
                    end
                end
                ST_DATA: begin
                    push          = 1'b1;
                    cmd.data_byte = s_tdata;
                    cmd.index     = taken_reg;
                    cmd.last      = data_last;
                    taken_next    = taken_sum[7:0];
                    if (data_last) begin
                        state_next = ST_PRE0;
                    end
                end
                default: state_next = ST_PRE0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_PRE0;
            sync_reg  <= SYNC_PATTERN_RESET;
            id_reg    <= '0;
            len_reg   <= '0;
            taken_reg <= '0;
        end else begin
            state_reg <= state_next;
            sync_reg  <= sync_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/pld_fifo.sv -----
// ---------------------------------------------------------------------------
// pld_fifo
// Short command queue between the classifier and the beat generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pld_fifo import pld_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire pld_cmd_t wr_cmd,
    input  wire logic     pop,
    output pld_cmd_t      rd_cmd,
    output pld_qstat_t    qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pld_cmd_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign qstat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign rd_cmd      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        // wrap at the last slot
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `PLD_ASSERT(a_no_pop_empty, pop |-> !qstat.empty, "queue popped while empty")
    `PLD_ASSERT(a_no_push_full, push |-> !qstat.full, "queue pushed while full")
    `PLD_ASSERT(a_count_step, (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1), "count lost a push")

endmodule

`default_nettype wire

// ----- design/pld_back.sv -----
// ---------------------------------------------------------------------------
// pld_back
// Beat generator: expands queued commands into registered output beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pld_back import pld_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire pld_cmd_t   cmd,
    input  wire pld_qstat_t qstat,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [15:0]     m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic [7:0] idx_reg, idx_next;
    logic       last_reg, last_next;
    logic       bad_reg, bad_next;
    logic       pend_reg, pend_next;
    pld_cmd_t   hold_reg, hold_next;
    logic       out_free;

    assign out_free = !valid_reg || m_tready;
    assign pop      = out_free && !pend_reg && !qstat.empty;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        bad_next   = bad_reg;
        pend_next  = pend_reg;
        hold_next  = hold_reg;
        if (out_free) begin
            if (pend_reg) begin
                // second beat of a header: the length byte
                valid_next = 1'b1;
                byte_next  = hold_reg.data_byte;
                idx_next   = INDEX_LENGTH;
                last_next  = hold_reg.last;
                bad_next   = 1'b0;
                pend_next  = 1'b0;
            end else if (pop) begin
                valid_next = 1'b1;
                if (cmd.pair) begin
                    byte_next = cmd.id_byte;
                    idx_next  = INDEX_ID;
                    last_next = 1'b0;
                    bad_next  = 1'b0;
                    pend_next = 1'b1;
                    hold_next = cmd;
                end else begin
                    byte_next = cmd.data_byte;
                    idx_next  = cmd.index;
                    last_next = cmd.last;
                    bad_next  = cmd.bad;
                end
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
        byte_reg <= byte_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
        hold_reg <= hold_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {idx_reg, byte_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = bad_reg;

    `PLD_ASSERT_ALWAYS(a_pend_no_pop, pend_reg |-> !pop, "popped while a header beat is pending")
    `PLD_ASSERT(a_pend_shown, pend_reg |-> valid_reg, "pending length beat without id beat shown")

endmodule

`default_nettype wire

// ----- design/preamble_length_deframer_unit.sv -----
// ---------------------------------------------------------------------------
// preamble_length_deframer_unit
// Sync-preamble hunter and length-prefixed frame receiver, top level.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one received byte per beat on s_tdata.
//   m_ channel: one message byte per beat, id first, then length, then data.
//     m_tdata carries the byte and its index in the message; m_tlast marks
//     the final byte of a message, or an error beat; m_tuser flags a length
//     byte below two, in which case the frame is dropped and the single beat
//     carries the bad length at index 1.
//   cfg channel: write the 32-bit preamble, first expected byte in the top
//     eight bits; always ready, write only while the block is idle.
// Throughput: one input beat per cycle while the queue has room. A valid
//   length byte yields two beats (id and length), which the beat generator
//   presents in turn; the command queue between the classifier and the
//   generator absorbs that. Path: an accepted byte's command is written
//   into the queue, then popped into the output register that presents it.
// Reset: the hunt restarts at the first preamble byte, the preamble returns
//   to AA55C33C, queue and output register are emptied.
// Stall: while m_tready is low the output beat holds; the classifier keeps
//   accepting until the queue fills, then s_tready drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module preamble_length_deframer_unit import pld_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // output beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] frame_byte, [15:8] byte_index
    output logic             m_tlast,   // last_of_frame
    output logic             m_tuser,   // [0] bad_length
    // preamble register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data   // sync_pattern
);

    pld_cmd_t   push_cmd;
    pld_cmd_t   head_cmd;
    pld_qstat_t qstat;
    logic       push;
    logic       pop;
    logic       cfg_write;

    // register writes are never held off
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // hunt the preamble, capture the header, classify each byte
    pld_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_write),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .push      (push),
        .cmd       (push_cmd)
    );

    // decouple classifier and beat generator
    pld_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_cmd  (push_cmd),
        .pop     (pop),
        .rd_cmd  (head_cmd),
        .qstat   (qstat)
    );

    // expand commands into registered output beats
    pld_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (head_cmd),
        .qstat    (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- tb/deframer_checker.sv -----
// ---------------------------------------------------------------------------
// deframer_checker
// Watches the byte, message and preamble channels of the frame receiver,
// predicts the message beats each received byte causes, and compares every
// message beat field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module deframer_checker import pld_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] frame_byte, [15:8] byte_index
    input  logic        m_tlast,   // last_of_frame
    input  logic        m_tuser,   // [0] bad_length
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,  // sync_pattern
    output int          mismatch_count,
    output int          beats_pending
);

    typedef enum logic [2:0] {
        HUNT_0, HUNT_1, HUNT_2, HUNT_3, TAKE_ID, TAKE_LENGTH, TAKE_DATA
    } rx_phase_e;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [7:0] byte_index;
        logic       last_of_frame;
        logic       bad_length;
    } frame_beat_t;

    logic [31:0] sync_word;
    rx_phase_e   rx_phase;
    logic [7:0]  msg_id;
    logic [7:0]  msg_length;
    logic [7:0]  bytes_taken;
    frame_beat_t expected_frame_beats[$];
    frame_beat_t want_beat;
    int          mismatches = 0;

    task automatic drop_to_hunt();
        rx_phase    = HUNT_0;
        msg_length  = '0;
        bytes_taken = '0;
    endtask

    task automatic expect_beat(input logic [7:0] b, input logic [7:0] idx,
                               input logic last, input logic bad);
        expected_frame_beats.push_back({b, idx, last, bad});
    endtask

    task automatic predict_frame_beats(input logic [7:0] rx);
        logic [7:0] want;
        case (rx_phase)
            HUNT_0, HUNT_1, HUNT_2, HUNT_3: begin
                // first preamble byte sits in the top eight bits
                want = sync_word[8 * (3 - rx_phase) +: 8];
                rx_phase = (rx == want) ? rx_phase_e'(rx_phase + 1) : HUNT_0;
            end
            TAKE_ID: begin
                msg_id   = rx;
                rx_phase = TAKE_LENGTH;
            end
            TAKE_LENGTH: begin
                if (rx < LENGTH_MIN) begin
                    expect_beat(rx, INDEX_LENGTH, 1'b1, 1'b1);
                    drop_to_hunt();
                end else begin
                    expect_beat(msg_id, INDEX_ID, 1'b0, 1'b0);
                    if (rx == LENGTH_MIN) begin
                        expect_beat(rx, INDEX_LENGTH, 1'b1, 1'b0);
                        drop_to_hunt();
                    end else begin
                        expect_beat(rx, INDEX_LENGTH, 1'b0, 1'b0);
                        msg_length  = rx;
                        bytes_taken = 8'd2;
                        rx_phase    = TAKE_DATA;
                    end
                end
            end
            TAKE_DATA: begin
                if (bytes_taken + 8'd1 >= msg_length) begin
                    expect_beat(rx, bytes_taken, 1'b1, 1'b0);
                    drop_to_hunt();
                end else begin
                    expect_beat(rx, bytes_taken, 1'b0, 1'b0);
                    bytes_taken = bytes_taken + 8'd1;
                end
            end
            default: drop_to_hunt();
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            sync_word = SYNC_PATTERN_RESET;
            msg_id    = '0;
            drop_to_hunt();
            expected_frame_beats.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                sync_word = cfg_data;
            if (s_tvalid && s_tready)
                predict_frame_beats(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_frame_beats.size() == 0) begin
                    $error("unexpected beat: frame_byte %0h byte_index %0d",
                           m_tdata[7:0], m_tdata[15:8]);
                    mismatches++;
                end else begin
                    want_beat = expected_frame_beats.pop_front();
                    if (m_tdata[7:0] !== want_beat.frame_byte) begin
                        $error("frame_byte: expected %0h, got %0h",
                               want_beat.frame_byte, m_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_tdata[15:8] !== want_beat.byte_index) begin
                        $error("byte_index: expected %0d, got %0d",
                               want_beat.byte_index, m_tdata[15:8]);
                        mismatches++;
                    end
                    if (m_tlast !== want_beat.last_of_frame) begin
                        $error("last_of_frame: expected %0b, got %0b",
                               want_beat.last_of_frame, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser !== want_beat.bad_length) begin
                        $error("bad_length: expected %0b, got %0b",
                               want_beat.bad_length, m_tuser);
                        mismatches++;
                    end
                end
            end
        end
        mismatch_count <= mismatches;
        beats_pending  <= expected_frame_beats.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Drives received bytes into the preamble/length frame receiver: a short
// directed run over the special cases, then random frames, broken preambles
// and noise under several preamble settings, with random idling on both
// channels. The checker beside the block scores every message beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import pld_pkg::*;

    localparam int DIRECTED_ITEMS   = 29;
    localparam int PHASE_ITEMS      = 270;
    localparam int NUM_PHASES       = 6;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 150;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    int          mismatch_count;
    int          beats_pending;

    // sender side bookkeeping
    int          rx_items_sent = 0;
    int          tx_beats      = 0;
    int          tx_idle_pct   = 0;
    logic [31:0] sync_now      = SYNC_PATTERN_RESET;

    // receiver side: the stimulus asks for a long hold by bumping a counter,
    // the receiver process serves it on its own clock count
    int          hold_requests = 0;
    int          holds_served  = 0;
    int          rx_stall_left = 0;
    int          rx_stall_pct  = 0;
    int          rx_window     = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    preamble_length_deframer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    deframer_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .beats_pending  (beats_pending)
    );

    // Receiver: pick a stall rate per window of cycles (zero gives calm
    // stretches), mostly short stalls with the odd long one, and serve any
    // long hold the stimulus asks for.
    always @(posedge aclk) begin
        if (rx_window == 0) begin
            rx_window = 128;
            case ($urandom_range(0, 3))
                0: rx_stall_pct = 0;
                1: rx_stall_pct = 10;
                2: rx_stall_pct = 25;
                default: rx_stall_pct = 50;
            endcase
        end
        rx_window--;
        if (holds_served != hold_requests) begin
            holds_served++;
            rx_stall_left = LONG_HOLD_CYCLES;
        end
        if (rx_stall_left != 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                        : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one byte, maybe after a random gap, and hold it until it is taken.
    // Counted beats are the ones that take part in framing; noise is not.
    task automatic put_rx_byte(input logic [7:0] b, input logic counted);
        int gap;
        if (tx_beats % 64 == 0) begin
            case ($urandom_range(0, 3))
                0, 1: tx_idle_pct = 0;
                2: tx_idle_pct = 15;
                default: tx_idle_pct = 40;
            endcase
        end
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                              : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        tx_beats++;
        if (counted)
            rx_items_sent++;
    endtask

    // Preamble (top byte first), id, length, then length-2 random data bytes.
    task automatic send_frame(input logic [31:0] sync, input logic [7:0] id,
                              input logic [7:0] length);
        for (int i = 3; i >= 0; i--)
            put_rx_byte(sync[8 * i +: 8], 1'b1);
        put_rx_byte(id, 1'b1);
        put_rx_byte(length, 1'b1);
        for (int i = 2; i < length; i++)
            put_rx_byte(8'($urandom), 1'b1);
    endtask

    // Drop valid and hold until every predicted beat has come out. The
    // checker publishes its count by nonblocking update, so read it after an edge.
    task automatic wait_for_frame_beats();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (beats_pending != 0);
    endtask

    // Only write the preamble with the block idle: drain, then let the last
    // header byte (which gives no beat) clear the pipeline.
    task automatic write_sync_pattern(input logic [31:0] value);
        wait_for_frame_beats();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int          pick;
        int          k;
        logic [7:0]  frame_length;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: mismatch in the hunt, length of two, both short lengths
        // (extreme bytes 00 and FF among them), a frame with data.
        put_rx_byte(SYNC_PATTERN_RESET[31:24], 1'b1);
        put_rx_byte(SYNC_PATTERN_RESET[23:16], 1'b1);
        put_rx_byte(8'h00, 1'b1);
        send_frame(SYNC_PATTERN_RESET, 8'hFF, 8'd2);
        send_frame(SYNC_PATTERN_RESET, 8'h00, 8'd0);
        send_frame(SYNC_PATTERN_RESET, 8'h5A, 8'd1);
        send_frame(SYNC_PATTERN_RESET, 8'h80, 8'd4);

        // Random: one preamble setting per phase, extremes among them, the
        // last phase restoring the reset value.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                case (p)
                    1: sync_now = 32'hFFFF_FFFF;
                    2: sync_now = 32'h0000_0000;
                    5: sync_now = SYNC_PATTERN_RESET;
                    default: sync_now = $urandom;
                endcase
                write_sync_pattern(sync_now);
            end
            // stall the receiver long enough to back the block up
            if (p == 1 || p == 4)
                hold_requests++;
            while (rx_items_sent < DIRECTED_ITEMS + (p + 1) * PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    // line noise
                    k = $urandom_range(1, 4);
                    repeat (k) put_rx_byte(8'($urandom), 1'b0);
                end else if (pick < 14) begin
                    // preamble broken off partway
                    k = $urandom_range(1, 3);
                    for (int i = 0; i < k; i++)
                        put_rx_byte(sync_now[24 - 8 * i +: 8], 1'b1);
                    put_rx_byte(sync_now[24 - 8 * k +: 8] ^ 8'($urandom_range(1, 255)),
                                1'b1);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 7)
                        frame_length = 8'($urandom_range(0, 1));
                    else if (pick < 10)
                        frame_length = 8'd255;
                    else if (pick < 14)
                        frame_length = 8'($urandom_range(13, 254));
                    else
                        frame_length = 8'($urandom_range(2, 12));
                    send_frame(sync_now, 8'($urandom), frame_length);
                end
            end
        end

        wait_for_frame_beats();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && beats_pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #1_500_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
